@@ hw/rtl/slt_pkg.sv @@
package slt_pkg;

    // Longest line whose columns are tracked exactly; later columns saturate.
    localparam int LINE_MAX = 256;
    localparam logic [7:0] COL_CAP = 8'((LINE_MAX > 256) ? 255 : (LINE_MAX - 1));

    // Depth of the result queue in front of the output port.
    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Scanner modes.
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_WORD = 2'd1;
    localparam logic [1:0] M_STR  = 2'd2;
    localparam logic [1:0] M_SKIP = 2'd3;

    // Keyword match progress that means no match.
    localparam logic [2:0] KP_NONE = 3'd7;
    localparam logic [2:0] KP_FULL = 3'd4;

    // Token kinds.
    localparam logic [3:0] K_SHOW  = 4'd0;
    localparam logic [3:0] K_PLUS  = 4'd1;
    localparam logic [3:0] K_MINUS = 4'd2;
    localparam logic [3:0] K_MUL   = 4'd3;
    localparam logic [3:0] K_DIV   = 4'd4;
    localparam logic [3:0] K_STR   = 4'd5;
    localparam logic [3:0] K_INT   = 4'd6;
    localparam logic [3:0] K_SEMI  = 4'd7;
    localparam logic [3:0] K_VAR   = 4'd8;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_UNTERM  = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  status;
        logic [7:0]  start_col;
        logic [8:0]  length;
        logic [15:0] token_line;
        logic        last;
    } t_result;

    // Results produced by one character, in delivery order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [7:0] kw_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = "s";
            2'd1:    c = "h";
            2'd2:    c = "o";
            default: c = "w";
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_next(input logic [2:0] kp, input logic [7:0] c);
        logic [2:0] n;
        if (kp < KP_FULL && c == kw_char(kp[1:0])) begin
            n = kp + 3'd1;
        end else begin
            n = KP_NONE;
        end
        return n;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {["0":"9"], ["A":"Z"], ["a":"z"]});
    endfunction

endpackage

@@ hw/rtl/slt_core.sv @@
module slt_core #(
    parameter int LINE_MAX = slt_pkg::LINE_MAX
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_ch,
    input  logic                 i_line_end,
    input  logic [15:0]          i_line_num,
    input  logic                 i_room,
    output slt_pkg::t_push       o_push
);
    import slt_pkg::*;

    // Last column that can be held; later characters of a line sit here.
    localparam logic [7:0] COL_LAST = 8'((LINE_MAX > 256) ? 255 : (LINE_MAX - 1));

    logic        r_in_valid;
    logic [7:0]  r_ch;
    logic        r_eol;
    logic [15:0] r_line;

    logic [1:0]  r_mode,      n_mode;
    logic [7:0]  r_column,    n_column;
    logic [7:0]  r_tstart,    n_tstart;
    logic        r_digit,     n_digit;
    logic [2:0]  r_kp,        n_kp;
    logic        r_overflowed, n_overflowed;
    logic        r_col_full,  n_col_full;

    logic        accept;
    logic        advance;

    logic        of;
    logic        at_cap;
    logic [7:0]  idx;
    logic        alnum;
    logic        done;
    logic        e1_v, e2_v, rep_v;
    t_result     e1, e2, rep;
    t_push       push;
    logic [2:0]  kp_word;
    logic [2:0]  kp_first;
    logic        digit_first;

    assign advance    = r_in_valid & i_room;
    assign o_in_ready = ~r_in_valid | i_room;
    assign accept     = i_in_valid & o_in_ready;

    function automatic logic [1:0] adj(input logic [1:0] st, input logic ovf);
        return (st == ST_OK && ovf) ? ST_LONG : st;
    endfunction

    function automatic logic [3:0] word_kind(input logic [2:0] kp, input logic dg);
        return (kp == KP_FULL) ? K_SHOW : (dg ? K_INT : K_VAR);
    endfunction

    always_comb begin
        of          = r_overflowed | r_col_full;
        at_cap      = (r_column >= COL_LAST);
        idx         = at_cap ? COL_LAST : r_column;
        alnum       = is_alnum(r_ch);
        kp_word     = kw_next(r_kp, r_ch);
        kp_first    = kw_next(3'd0, r_ch);
        digit_first = (r_ch inside {["0":"9"]});

        n_mode       = r_mode;
        n_column     = at_cap ? COL_LAST : r_column + 8'd1;
        n_tstart     = r_tstart;
        n_digit      = r_digit;
        n_kp         = r_kp;
        n_overflowed = of;
        n_col_full   = r_col_full | at_cap;

        done = 1'b0;
        e1_v = 1'b0;
        e2_v = 1'b0;
        e1   = '0;
        e2   = '0;
        rep  = '0;
        e1.token_line = r_line;
        e2.token_line = r_line;
        rep.token_line = r_line;

        case (r_mode)
            M_SKIP: begin
                done = 1'b1;
            end
            M_STR: begin
                e1.kind      = K_STR;
                e1.start_col = r_tstart;
                e1.length    = {1'b0, idx} - {1'b0, r_tstart} + 9'd1;
                if (r_ch == "\"") begin
                    e1_v      = 1'b1;
                    e1.status = adj(ST_OK, of);
                    n_mode    = M_IDLE;
                end else if (r_eol) begin
                    e1_v      = 1'b1;
                    e1.status = ST_UNTERM;
                end
                done = 1'b1;
            end
            M_WORD: begin
                e1.start_col = r_tstart;
                e1.status    = adj(ST_OK, of);
                if (alnum) begin
                    n_kp      = kp_word;
                    e1.kind   = word_kind(kp_word, r_digit);
                    e1.length = {1'b0, idx} - {1'b0, r_tstart} + 9'd1;
                    e1_v      = r_eol;
                    done      = 1'b1;
                end else begin
                    e1.kind   = word_kind(r_kp, r_digit);
                    e1.length = {1'b0, idx} - {1'b0, r_tstart};
                    e1_v      = 1'b1;
                    n_mode    = M_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (!done) begin
            e2.start_col = idx;
            e2.length    = 9'd1;
            e2.status    = adj(ST_OK, of);
            case (r_ch)
                " ": begin
                end
                "+": begin
                    e2_v    = 1'b1;
                    e2.kind = K_PLUS;
                end
                "-": begin
                    e2_v    = 1'b1;
                    e2.kind = K_MINUS;
                end
                "*": begin
                    e2_v    = 1'b1;
                    e2.kind = K_MUL;
                end
                "/": begin
                    e2_v    = 1'b1;
                    e2.kind = K_DIV;
                end
                ";": begin
                    e2_v    = 1'b1;
                    e2.kind = K_SEMI;
                end
                "=", "<", ">", "{", "}", "[", "]", "(", ")": begin
                    e2_v    = 1'b1;
                    e2.kind = K_VAR;
                end
                "\"": begin
                    n_tstart  = idx;
                    n_mode    = M_STR;
                    e2_v      = r_eol;
                    e2.kind   = K_STR;
                    e2.status = ST_UNTERM;
                end
                default: begin
                    if (alnum) begin
                        n_tstart = idx;
                        n_digit  = digit_first;
                        n_kp     = kp_first;
                        n_mode   = M_WORD;
                        e2_v     = r_eol;
                        e2.kind  = word_kind(kp_first, digit_first);
                    end else begin
                        e2_v      = 1'b1;
                        e2.kind   = K_SHOW;
                        e2.status = ST_UNKNOWN;
                        n_mode    = M_SKIP;
                    end
                end
            endcase
        end

        // Report for a line that overflowed but ended without a token.
        rep_v         = r_eol & of & ~e1_v & ~e2_v;
        rep.kind      = K_SHOW;
        rep.status    = ST_LONG;
        rep.start_col = 8'd0;
        rep.length    = 9'd1;

        if (r_eol) begin
            n_mode       = M_IDLE;
            n_column     = 8'd0;
            n_overflowed = 1'b0;
            n_col_full   = 1'b0;
        end

        push = '0;
        if (e1_v) begin
            push.res0 = e1;
            push.res1 = e2;
            push.cnt  = e2_v ? 2'd2 : 2'd1;
        end else if (e2_v) begin
            push.res0 = e2;
            push.cnt  = 2'd1;
        end else if (rep_v) begin
            push.res0 = rep;
            push.cnt  = 2'd1;
        end
        push.res0.last = (push.cnt == 2'd1);
        push.res1.last = 1'b1;
        if (!advance) begin
            push.cnt = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mode       <= M_IDLE;
            r_column     <= 8'd0;
            r_tstart     <= 8'd0;
            r_digit      <= 1'b0;
            r_kp         <= 3'd0;
            r_overflowed <= 1'b0;
            r_col_full   <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_mode       <= n_mode;
                r_column     <= n_column;
                r_tstart     <= n_tstart;
                r_digit      <= n_digit;
                r_kp         <= n_kp;
                r_overflowed <= n_overflowed;
                r_col_full   <= n_col_full;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch   <= i_ch;
            r_eol  <= i_line_end;
            r_line <= i_line_num;
        end
    end

endmodule

@@ hw/rtl/slt_queue.sv @@
module slt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slt_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output slt_pkg::t_result o_head
);
    import slt_pkg::*;

    t_result          r_q [QDEPTH];
    t_result          n_q [QDEPTH];
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic [QCW-1:0]   base;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid & i_ready;
    assign o_room  = (r_cnt <= QCW'(QDEPTH - 2));
    assign o_head  = r_q[0];

    always_comb begin
        base  = r_cnt - QCW'(pop);
        n_cnt = base + QCW'(i_push.cnt);
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push.cnt != 2'd0 && base == QCW'(i)) begin
                n_q[i] = i_push.res0;
            end
            if (i_push.cnt == 2'd2 && base + QCW'(1) == QCW'(i)) begin
                n_q[i] = i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

@@ hw/rtl/source_line_tokenizer.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_ch, i_line_end, i_line_num
// result    out        o_out_valid / i_out_ready  o_kind, o_status, o_start_col,
//                                                 o_length, o_token_line, o_last
//
// One character is taken per cycle while input is not stalled. It is held
// in the input register, where the scanner classifies it and updates its
// state, and the zero to two results it causes are written into a four-entry
// result queue. The first result of a character reaches the output through
// the input register and then the registered queue, behind earlier results.
// Input is stalled only while the input register holds a character and the
// queue cannot take two more results, so one character per cycle is sustained
// as long as the consumer takes results as fast as the characters cause them.
// Reset is synchronous and empties the pipeline; no clearing pass is needed.
module source_line_tokenizer #(
    parameter int LINE_MAX = slt_pkg::LINE_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_line_end,
    input  logic [15:0] i_line_num,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_start_col,
    output logic [8:0]  o_length,
    output logic [15:0] o_token_line,
    output logic        o_last
);
    import slt_pkg::*;

    // Results of the character in the input register, qualified by the
    // queue having room for both of them.
    t_push   push;
    logic    room;
    t_result head;

    // The line length sets the column at which positions saturate.
    slt_core #(
        .LINE_MAX (LINE_MAX)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_ch          (i_ch),
        .i_line_end    (i_line_end),
        .i_line_num    (i_line_num),
        .i_room        (room),
        .o_push        (push)
    );

    // The queue head is itself a register, so the output port is registered
    // and a stalled consumer never blocks the scanner while two slots are free.
    slt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    assign o_kind       = head.kind;
    assign o_status     = head.status;
    assign o_start_col  = head.start_col;
    assign o_length     = head.length;
    assign o_token_line = head.token_line;
    assign o_last       = head.last;

endmodule

@@ hw/rtl/slt_checker.sv @@
module slt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_kind,
    input logic [1:0]  o_status,
    input logic [7:0]  o_start_col,
    input logic [8:0]  o_length,
    input logic [15:0] o_token_line,
    input logic        o_last
);
    import slt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) &&
        $stable(o_status) && $stable(o_start_col) && $stable(o_length) &&
        $stable(o_token_line) && $stable(o_last))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= K_VAR)
        else $error("kind out of range");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_UNKNOWN |-> o_kind == K_SHOW && o_length == 9'd1)
        else $error("unknown character report malformed");

    a_unterm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_UNTERM |-> o_kind == K_STR && o_last)
        else $error("unterminated string report malformed");

endmodule

bind source_line_tokenizer slt_checker u_slt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_status     (o_status),
    .o_start_col  (o_start_col),
    .o_length     (o_length),
    .o_token_line (o_token_line),
    .o_last       (o_last)
);
